/* hw/rtl/hsvrgb_pkg.sv */
// Package for the HSV to RGB converter: word types, sector codes and the
// fixed reciprocal constants used by the pipeline. No dependencies.
`default_nettype none

package hsvrgb_pkg;

  localparam int unsigned HUE_W = 13;
  localparam int unsigned CH_W  = 8;

  // Hue divided by four before the divide by 15 that yields the sector count.
  localparam int unsigned E_W   = HUE_W - 2;
  // Raw sector count before the modulo six, at most 136.
  localparam int unsigned Q_W   = 8;
  // Scaled channel value ahead of the divide by 3825, below 979200.
  localparam int unsigned B_W   = 20;
  localparam int unsigned C1_W  = 19;
  localparam int unsigned C2_W  = 16;

  // Reciprocals: x / n is (x * RECIP) >> SHIFT, exact over the value ranges above.
  localparam logic [11:0] RECIP15   = 12'd2185;
  localparam int unsigned SHIFT15   = 15;
  localparam logic [7:0]  RECIP6    = 8'd171;
  localparam int unsigned SHIFT6    = 10;
  localparam logic [19:0] RECIP3    = 20'd699051;
  localparam int unsigned SHIFT3    = 21;
  localparam logic [18:0] RECIP5    = 19'd419431;
  localparam int unsigned SHIFT5    = 21;
  localparam logic [17:0] RECIP255  = 18'd131587;
  localparam int unsigned SHIFT255  = 25;

  // Largest legal scaled channel value plus one: 256 * 3825.
  localparam logic [B_W-1:0] B_LIMIT = 20'd979200;

  // The six 60-degree hue sectors.
  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  brightness;
  } hsv_word_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_word_t;

endpackage

`default_nettype wire

/* hw/rtl/hsv_to_rgb_converter_top.sv */
// HSV to RGB converter, seven-stage pipeline, one color word per clock while not stalled.
// Depends on hsvrgb_pkg for the word types, sector codes and reciprocals.
//
// Usage:
//   The input channel carries one HSV word (hue in 1/2^HUE_FRAC_BITS degree,
//   saturation and brightness as 8-bit fractions of full scale). The output
//   channel carries one RGB word with each channel rounded to nearest.
//   Both channels use valid and stall; a word moves at a rising edge where
//   valid is high and stall is low.
//   An accepted word passes through all seven pipeline registers before it is
//   offered. Throughput is one word per cycle while the receiver does not stall;
//   each pipeline register holds a valid bit, and an empty stage always accepts,
//   so bubbles are squeezed out while the receiver stalls.
//   When the receiver stalls, the output register holds its word and the
//   stages behind it keep filling; in_stall_o rises only once every stage
//   holds a word. Nothing is dropped or repeated.
//   Reset clears all valid bits; the pipeline is empty afterwards and the
//   first word can be taken in the cycle after reset is released.
//   Hue is reduced modulo a full circle, so exactly 360 degrees is red.
//   The rate is set by the pipeline itself: the divide by the common
//   denominator is a shift in stage 4 and three reciprocal multiplies in the
//   last three stages.
`default_nettype none

module hsv_to_rgb_converter_top
  import hsvrgb_pkg::*;
#(
  parameter int unsigned HUE_FRAC_BITS = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire hsv_word_t in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output rgb_word_t      out_word_o
);

  // One sector is 60 degrees in hue units; D = 255 * SECW is the common
  // denominator of all channel numerators.
  localparam int unsigned SECW   = 60 << HUE_FRAC_BITS;
  localparam int unsigned K_W    = $clog2(SECW + 1);
  localparam int unsigned F_W    = $clog2(SECW);
  localparam int unsigned D_HALF = (255 * SECW) / 2;
  localparam int unsigned NUM_W  = $clog2(255 * 255 * SECW + D_HALF + 1);
  localparam int unsigned DROP   = HUE_FRAC_BITS + 2;
  localparam int unsigned STAGES = 7;
  localparam int unsigned NCH    = 3;

  logic [STAGES-1:0] vq_q;
  logic [STAGES-1:0] en;

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[STAGES-1] = !vq_q[STAGES-1] || !out_stall_i;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !vq_q[i] || en[i+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= '0;
    end else begin
      if (en[0]) begin
        vq_q[0] <= in_valid_i;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          vq_q[i] <= vq_q[i-1];
        end
      end
    end
  end

  // Stage 1: raw sector count q = hue / SECW, taken as (hue >> (F+2)) / 15.
  logic [HUE_W-1:0]      s1_hue_q;
  logic [CH_W-1:0]       s1_sat_q;
  logic [CH_W-1:0]       s1_val_q;
  logic [Q_W-1:0]        s1_q_q;
  logic [Q_W-1:0]        s1_q_d;
  logic [E_W-1:0]        s1_e;
  logic [E_W+11:0]       s1_prod;

  always_comb begin
    s1_e    = E_W'(in_word_i.hue >> DROP);
    s1_prod = (E_W+12)'(s1_e) * (E_W+12)'(RECIP15);
    s1_q_d  = Q_W'(s1_prod >> SHIFT15);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_hue_q <= in_word_i.hue;
      s1_sat_q <= in_word_i.saturation;
      s1_val_q <= in_word_i.brightness;
      s1_q_q   <= s1_q_d;
    end
  end

  // Stage 2: sector = q mod 6, offset within the sector, and the two
  // brightness products V*S and V*(255-S).
  sector_e               s2_sector_q;
  sector_e               s2_sector_d;
  logic [F_W-1:0]        s2_f_q;
  logic [F_W-1:0]        s2_f_d;
  logic [2*CH_W-1:0]     s2_vs_q;
  logic [2*CH_W-1:0]     s2_vm_q;
  logic [2*CH_W-1:0]     s2_vs_d;
  logic [2*CH_W-1:0]     s2_vm_d;
  logic [2*Q_W-1:0]      s2_prod6;
  logic [Q_W-1:0]        s2_q6;
  logic [Q_W-1:0]        s2_q6x6;
  logic [Q_W-1:0]        s2_rem;
  logic [HUE_W-1:0]      s2_base;
  logic [HUE_W-1:0]      s2_off;

  always_comb begin
    s2_prod6    = (2*Q_W)'(s1_q_q) * (2*Q_W)'(RECIP6);
    s2_q6       = Q_W'(s2_prod6 >> SHIFT6);
    s2_q6x6     = (s2_q6 << 2) + (s2_q6 << 1);
    s2_rem      = s1_q_q - s2_q6x6;
    s2_sector_d = sector_e'(s2_rem[2:0]);
    s2_base     = HUE_W'(s1_q_q * SECW);
    s2_off      = s1_hue_q - s2_base;
    s2_f_d      = F_W'(s2_off);
    s2_vs_d     = (2*CH_W)'(s1_val_q) * (2*CH_W)'(s1_sat_q);
    s2_vm_d     = (2*CH_W)'(s1_val_q) * (2*CH_W)'(8'd255 - s1_sat_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_sector_q <= s2_sector_d;
      s2_f_q      <= s2_f_d;
      s2_vs_q     <= s2_vs_d;
      s2_vm_q     <= s2_vm_d;
    end
  end

  // Stage 3: numerators over D. The ramp term k rises through even sectors
  // and falls through odd ones.
  sector_e               s3_sector_q;
  logic [NUM_W-1:0]      s3_cn_q;
  logic [NUM_W-1:0]      s3_xn_q;
  logic [NUM_W-1:0]      s3_mn_q;
  logic [K_W-1:0]        s3_k;

  always_comb begin
    if (s2_sector_q[0]) begin
      s3_k = K_W'(SECW) - K_W'(s2_f_q);
    end else begin
      s3_k = K_W'(s2_f_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_sector_q <= s2_sector_q;
      s3_cn_q     <= NUM_W'(s2_vs_q * SECW);
      s3_xn_q     <= NUM_W'(NUM_W'(s2_vs_q) * NUM_W'(s3_k));
      s3_mn_q     <= NUM_W'(s2_vm_q * SECW);
    end
  end

  // Stage 4: place C and X by sector, add m and half of D for rounding,
  // then drop the factor 4 * 2^F of D, leaving a divide by 3825.
  logic [NUM_W-1:0]      s4_sel [NCH];
  logic [NUM_W-1:0]      s4_sum [NCH];
  logic [B_W-1:0]        s4_b_q [NCH];

  always_comb begin
    s4_sel[0] = '0;
    s4_sel[1] = '0;
    s4_sel[2] = '0;
    unique case (s3_sector_q)
      SEC_R_Y: begin
        s4_sel[0] = s3_cn_q;
        s4_sel[1] = s3_xn_q;
      end
      SEC_Y_G: begin
        s4_sel[0] = s3_xn_q;
        s4_sel[1] = s3_cn_q;
      end
      SEC_G_C: begin
        s4_sel[1] = s3_cn_q;
        s4_sel[2] = s3_xn_q;
      end
      SEC_C_B: begin
        s4_sel[1] = s3_xn_q;
        s4_sel[2] = s3_cn_q;
      end
      SEC_B_M: begin
        s4_sel[0] = s3_xn_q;
        s4_sel[2] = s3_cn_q;
      end
      default: begin
        s4_sel[0] = s3_cn_q;
        s4_sel[2] = s3_xn_q;
      end
    endcase
    for (int c = 0; c < NCH; c++) begin
      s4_sum[c] = s4_sel[c] + s3_mn_q + NUM_W'(D_HALF);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int c = 0; c < NCH; c++) begin
        s4_b_q[c] <= B_W'(s4_sum[c] >> DROP);
      end
    end
  end

  // Stages 5 to 7: divide by 3, by 5 and by 255 through reciprocals.
  logic [C1_W-1:0]       s5_c1_q [NCH];
  logic [C2_W-1:0]       s6_c2_q [NCH];
  logic [CH_W-1:0]       s7_ch_q [NCH];
  logic [2*B_W-1:0]      s5_prod [NCH];
  logic [2*C1_W-1:0]     s6_prod [NCH];
  logic [C2_W+17:0]      s7_prod [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      s5_prod[c] = (2*B_W)'(s4_b_q[c]) * (2*B_W)'(RECIP3);
      s6_prod[c] = (2*C1_W)'(s5_c1_q[c]) * (2*C1_W)'(RECIP5);
      s7_prod[c] = (C2_W+18)'(s6_c2_q[c]) * (C2_W+18)'(RECIP255);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NCH; c++) begin
      if (en[4]) begin
        s5_c1_q[c] <= C1_W'(s5_prod[c] >> SHIFT3);
      end
      if (en[5]) begin
        s6_c2_q[c] <= C2_W'(s6_prod[c] >> SHIFT5);
      end
      if (en[6]) begin
        s7_ch_q[c] <= CH_W'(s7_prod[c] >> SHIFT255);
      end
    end
  end

  assign out_valid_o      = vq_q[STAGES-1];
  assign out_word_o.red   = s7_ch_q[0];
  assign out_word_o.green = s7_ch_q[1];
  assign out_word_o.blue  = s7_ch_q[2];

  // The secondary component never exceeds chroma, since k stays within a sector.
  a_x_within_c : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vq_q[2] |-> (s3_xn_q <= s3_cn_q))
    else $error("secondary component exceeds chroma");

  // The input is only held off when every stage holds a word.
  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vq_q))
    else $error("input stalled with an empty stage");

  // Scaled channel values stay below 256 * 3825, so no channel wraps.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vq_q[3] |-> ((s4_b_q[0] < B_LIMIT) && (s4_b_q[1] < B_LIMIT)
                 && (s4_b_q[2] < B_LIMIT)))
    else $error("scaled channel value out of range");

endmodule

`default_nettype wire
